// File: rtl/preemptive_priority_scheduler_defines.svh
// assertion macros shared by the scheduler checker
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define PPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication, quiet while reset is high
`define PPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// File: rtl/pps_pkg.sv
// shared types and constants of the priority scheduler
`default_nettype none

package pps_pkg;

  // command codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam int PID_W   = 8;
  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int TIME_W  = 24;

  // runner id: pid with an extra top bit for the idle marker
  localparam logic [PID_W:0] IDLE_MARK = {1'b1, {PID_W{1'b0}}};

  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic               fits;
  } entry_t;

  // table write strobes
  typedef struct packed {
    logic we_entry;
    logic we_rem;
  } tbl_wr_t;

endpackage

`default_nettype wire

// File: rtl/pps_table.sv
// process table memory: static entry fields and remaining work
`default_nettype none

module pps_table
  import pps_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic               clk,
  input  tbl_wr_t            wr,
  input  logic [AW-1:0]      waddr,
  input  entry_t             wentry,
  input  logic [BURST_W-1:0] wrem,
  input  logic [AW-1:0]      raddr,
  output entry_t             rentry,
  output logic [BURST_W-1:0] rrem
);

  entry_t             mem_entry [DEPTH];
  logic [BURST_W-1:0] mem_rem   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we_entry) begin
      mem_entry[waddr] <= wentry;
    end
    if (wr.we_rem) begin
      mem_rem[waddr] <= wrem;
    end
    rentry <= mem_entry[raddr];
    rrem   <= mem_rem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/preemptive_priority_scheduler.sv
// preemptive priority scheduler: process table, sequential scan and tick reporting
//
// Commands are taken when start is high and busy is low. A load (op 0) appends
// one process entry (ignored when the table is full), a clear (op 2) empties
// the table and resets time and counts, and neither gives a result; op 3 is
// ignored. A tick (op 1) makes busy rise and scans the table one entry per cycle
// through the table's single read port, keeping the ready entry with the lowest
// priority number (earliest loaded wins ties). The winner is then read again
// (fetch), judged (eval) and the result is registered in a wait state; an idle
// tick goes from the scan straight to the wait state, and every entry dropped
// for lack of memory sends the tick back to a full rescan. The result is
// shown for exactly one cycle with done high and the receiver cannot stall it,
// so it must be captured on that edge; busy falls in the same cycle, so the
// next command may be given then.
`default_nettype none

module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // command transfer
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     op,
  input  logic [PID_W-1:0]               process_pid,
  input  logic [ARR_W-1:0]               arrival_time,
  input  logic [BURST_W-1:0]             burst_length,
  input  logic [PRIO_W-1:0]              priority_level,
  input  logic                           fits_memory,
  // result transfer
  output logic                           done,
  output logic [PID_W-1:0]               running_pid,
  output logic                           cpu_idle,
  output logic [TIME_W-1:0]              tick_time,
  output logic                           new_segment,
  output logic                           process_finished,
  output logic [TIME_W-1:0]              turnaround,
  output logic [TIME_W-1:0]              waiting,
  output logic [$clog2(MAX_PROCS+1)-1:0] dropped_count,
  output logic                           all_done
);

  // index width for the table, count width that can hold MAX_PROCS itself
  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_PROCS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_EVAL,
    S_WAIT
  } state_t;

  state_t              state;
  logic [CW-1:0]       entry_count;
  logic [CW-1:0]       completed_count;
  logic [TIME_W-1:0]   time_now;
  logic [PID_W:0]      previous_runner;
  logic [PID_W:0]      chart_last;
  logic [MAX_PROCS-1:0] entry_done;
  logic [CW-1:0]       drops;

  // scan pipeline: issue counter, then one registered read stage
  logic [CW-1:0]       iss;
  logic                vld_d;
  logic [IW-1:0]       idx_d;
  logic                best_found;
  logic [IW-1:0]       best_idx;
  logic [PRIO_W-1:0]   best_prio;

  // table port
  tbl_wr_t             tbl_wr;
  logic [IW-1:0]       tbl_waddr;
  logic [IW-1:0]       tbl_raddr;
  entry_t              tbl_wentry;
  logic [BURST_W-1:0]  tbl_wrem;
  entry_t              rentry;
  logic [BURST_W-1:0]  rrem;

  logic                accept;
  logic                load_ok;
  logic                issue_more;
  logic                candidate;
  logic                drop_now;
  logic                finish_now;
  logic [PID_W:0]      pid_ext;
  logic [TIME_W-1:0]   time_plus;
  logic [BURST_W-1:0]  rem_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign load_ok = accept && (op == OP_LOAD) && (entry_count < FULL);

  assign issue_more = (iss < entry_count);
  assign time_plus  = time_now + TIME_W'(1);
  assign pid_ext    = {1'b0, rentry.pid};

  // the compare of the scan: is the entry just read more urgent than the best so far
  assign candidate = vld_d && !entry_done[idx_d]
                     && ({{(TIME_W-ARR_W){1'b0}}, rentry.arrival} <= time_now)
                     && (!best_found || (rentry.prio < best_prio));

  // memory check only when the picked pid is not the one already resident
  assign drop_now   = (previous_runner != pid_ext) && !rentry.fits;
  // a zero burst is run as one unit of work
  assign finish_now = (rrem <= BURST_W'(1));
  assign rem_next   = finish_now ? '0 : rrem - BURST_W'(1);

  always_comb begin
    tbl_wr.we_entry = load_ok;
    tbl_wr.we_rem   = load_ok || ((state == S_EVAL) && !drop_now);
    tbl_waddr       = (state == S_EVAL) ? best_idx : entry_count[IW-1:0];
    tbl_raddr       = (state == S_SCAN) ? iss[IW-1:0] : best_idx;
    tbl_wentry      = '{pid: process_pid, arrival: arrival_time, burst: burst_length,
                        prio: priority_level, fits: fits_memory};
    tbl_wrem        = load_ok ? burst_length : rem_next;
  end

  pps_table #(
    .DEPTH (MAX_PROCS),
    .AW    (IW)
  ) u_table (
    .clk    (clk),
    .wr     (tbl_wr),
    .waddr  (tbl_waddr),
    .wentry (tbl_wentry),
    .wrem   (tbl_wrem),
    .raddr  (tbl_raddr),
    .rentry (rentry),
    .rrem   (rrem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      entry_count     <= '0;
      completed_count <= '0;
      time_now        <= '0;
      previous_runner <= IDLE_MARK;
      chart_last      <= IDLE_MARK;
      entry_done      <= '0;
      vld_d           <= 1'b0;
      best_found      <= 1'b0;
      done            <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (load_ok) begin
            entry_done[entry_count[IW-1:0]] <= 1'b0;
            entry_count <= entry_count + CW'(1);
          end
          if (accept && (op == OP_CLEAR)) begin
            entry_count     <= '0;
            completed_count <= '0;
            time_now        <= '0;
            previous_runner <= IDLE_MARK;
            chart_last      <= IDLE_MARK;
            entry_done      <= '0;
          end
          if (accept && (op == OP_TICK)) begin
            tick_time  <= time_now;
            drops      <= '0;
            iss        <= '0;
            vld_d      <= 1'b0;
            best_found <= 1'b0;
            state      <= S_SCAN;
          end
        end

        S_SCAN: begin
          // issue the next read while judging the entry read last cycle
          vld_d <= issue_more;
          idx_d <= iss[IW-1:0];
          if (issue_more) begin
            iss <= iss + CW'(1);
          end
          if (candidate) begin
            best_found <= 1'b1;
            best_idx   <= idx_d;
            best_prio  <= rentry.prio;
          end
          if (!issue_more && !vld_d) begin
            if (best_found) begin
              state <= S_FETCH;
            end else begin
              // nothing ready: idle tick
              time_now         <= time_plus;
              previous_runner  <= IDLE_MARK;
              cpu_idle         <= 1'b1;
              running_pid      <= '0;
              new_segment      <= 1'b0;
              process_finished <= 1'b0;
              turnaround       <= '0;
              state            <= S_WAIT;
            end
          end
        end

        S_FETCH: begin
          // read of the winner is in flight
          state <= S_EVAL;
        end

        S_EVAL: begin
          if (drop_now) begin
            // no room in memory: drop it and rescan within this tick
            entry_done[best_idx] <= 1'b1;
            completed_count      <= completed_count + CW'(1);
            drops                <= drops + CW'(1);
            previous_runner      <= IDLE_MARK;
            iss                  <= '0;
            vld_d                <= 1'b0;
            best_found           <= 1'b0;
            state                <= S_SCAN;
          end else begin
            running_pid      <= rentry.pid;
            cpu_idle         <= 1'b0;
            new_segment      <= (chart_last != pid_ext);
            chart_last       <= pid_ext;
            time_now         <= time_plus;
            process_finished <= finish_now;
            if (finish_now) begin
              entry_done[best_idx] <= 1'b1;
              completed_count      <= completed_count + CW'(1);
              previous_runner      <= IDLE_MARK;
              turnaround <= time_plus - {{(TIME_W-ARR_W){1'b0}}, rentry.arrival};
            end else begin
              previous_runner <= pid_ext;
              turnaround      <= '0;
            end
            state <= S_WAIT;
          end
        end

        S_WAIT: begin
          // second subtract for waiting time, then present the result
          waiting <= process_finished
                     ? turnaround - {{(TIME_W-BURST_W){1'b0}}, rentry.burst}
                     : '0;
          dropped_count <= drops;
          all_done      <= (completed_count >= entry_count);
          done          <= 1'b1;
          state         <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/pps_checker.sv
// port-level checks of the scheduler, bound to the top level
`default_nettype none

`include "preemptive_priority_scheduler_defines.svh"

module pps_checker
  import pps_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [1:0]        op,
  input logic              done,
  input logic              cpu_idle,
  input logic [PID_W-1:0]  running_pid,
  input logic              new_segment,
  input logic              process_finished,
  input logic [TIME_W-1:0] turnaround,
  input logic [TIME_W-1:0] waiting
);

  // a tick transfer always occupies the block
  `PPS_ASSERT_NEXT(a_tick_busy, clk, rst, start && !busy && (op == OP_TICK), busy)

  // results are shown only once the block has gone idle, one cycle at a time
  `PPS_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  `PPS_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)

  // idle ticks report no runner and no completion
  `PPS_ASSERT_NOW(a_idle_quiet, clk, rst, done && cpu_idle,
                  (running_pid == '0) && !new_segment && !process_finished)

  // times are only reported for a completing process
  `PPS_ASSERT_NOW(a_times_zero, clk, rst, done && !process_finished,
                  (turnaround == '0) && (waiting == '0))

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .op               (op),
  .done             (done),
  .cpu_idle         (cpu_idle),
  .running_pid      (running_pid),
  .new_segment      (new_segment),
  .process_finished (process_finished),
  .turnaround       (turnaround),
  .waiting          (waiting)
);

`default_nettype wire

// File: sim/preemptive_priority_scheduler_tb.sv
// testbench of the preemptive priority scheduler: directed and random commands with a predictor
module preemptive_priority_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pps_pkg::*;

  localparam int NPROC  = 16;
  localparam int DROP_W = $clog2(NPROC + 1);
  // op 3 has no meaning, the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // cycles to watch for stray results once the last tick report is in
  localparam int SETTLE_CYCLES = 400;
  // cap on printed mismatch lines
  localparam int PRINT_CAP = 150;

  // one tick report as the block presents it
  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic              idle;
    logic [TIME_W-1:0] tick_at;
    logic              seg;
    logic              fin;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wait_t;
    logic [DROP_W-1:0] drops;
    logic              all_fin;
  } tick_report_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] op = OP_LOAD;
  logic [PID_W-1:0] process_pid = '0;
  logic [ARR_W-1:0] arrival_time = '0;
  logic [BURST_W-1:0] burst_length = '0;
  logic [PRIO_W-1:0] priority_level = '0;
  logic fits_memory = 1'b0;

  logic busy;
  logic done;
  logic [PID_W-1:0] running_pid;
  logic cpu_idle;
  logic [TIME_W-1:0] tick_time;
  logic new_segment;
  logic process_finished;
  logic [TIME_W-1:0] turnaround;
  logic [TIME_W-1:0] waiting;
  logic [DROP_W-1:0] dropped_count;
  logic all_done;

  preemptive_priority_scheduler #(.MAX_PROCS(NPROC)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .process_pid(process_pid),
    .arrival_time(arrival_time),
    .burst_length(burst_length),
    .priority_level(priority_level),
    .fits_memory(fits_memory),
    .done(done),
    .running_pid(running_pid),
    .cpu_idle(cpu_idle),
    .tick_time(tick_time),
    .new_segment(new_segment),
    .process_finished(process_finished),
    .turnaround(turnaround),
    .waiting(waiting),
    .dropped_count(dropped_count),
    .all_done(all_done)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // predictor state: our own copy of the process table and the clock
  // ---------------------------------------------------------------------
  logic [PID_W-1:0]   tbl_pid       [NPROC];
  logic [ARR_W-1:0]   tbl_arrival   [NPROC];
  logic [BURST_W-1:0] tbl_burst     [NPROC];
  logic [BURST_W-1:0] tbl_remaining [NPROC];
  logic [PRIO_W-1:0]  tbl_prio      [NPROC];
  logic               tbl_fits      [NPROC];
  logic               tbl_done      [NPROC];
  int                 tbl_count;
  logic [TIME_W-1:0]  sched_now;
  logic [PID_W:0]     mem_runner;    // pid held in memory, or the idle marker
  logic [PID_W:0]     chart_runner;  // pid of the last chart segment, or none
  int                 retired_count; // finished plus dropped

  // reports still owed by the block, oldest first
  tick_report_t tick_reports_due[$];

  int mismatches = 0;
  int items_applied = 0;  // items that change the block's state
  bit steady_mode = 1'b0; // no random gaps between commands while set

  function automatic void clear_table();
    for (int i = 0; i < NPROC; i++) begin
      tbl_done[i] = 1'b0;
    end
    tbl_count = 0;
    sched_now = '0;
    mem_runner = IDLE_MARK;
    chart_runner = IDLE_MARK;
    retired_count = 0;
  endfunction

  // most urgent ready entry, earliest loaded wins ties; -1 when none
  function automatic int most_urgent_ready();
    int best;
    best = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (!tbl_done[i] && {{(TIME_W-ARR_W){1'b0}}, tbl_arrival[i]} <= sched_now) begin
        if (best < 0 || tbl_prio[i] < tbl_prio[best]) best = i;
      end
    end
    return best;
  endfunction

  // one time unit of scheduling; drops rescan within the same tick
  function automatic tick_report_t schedule_one_tick();
    tick_report_t r;
    int k;
    int ndrop;
    bit scanning;
    logic [TIME_W-1:0] ta;
    r = '0;
    r.tick_at = sched_now;
    ndrop = 0;
    scanning = 1'b1;
    while (scanning) begin
      k = most_urgent_ready();
      if (k < 0) begin
        // nothing ready: idle tick, chart segment kept
        sched_now = sched_now + TIME_W'(1);
        mem_runner = IDLE_MARK;
        r.idle = 1'b1;
        scanning = 1'b0;
      end else if (mem_runner != {1'b0, tbl_pid[k]} && !tbl_fits[k]) begin
        // memory check only on a pid change; failure drops the entry
        tbl_done[k] = 1'b1;
        retired_count++;
        ndrop++;
        mem_runner = IDLE_MARK;
      end else begin
        r.pid = tbl_pid[k];
        r.seg = (chart_runner != {1'b0, tbl_pid[k]});
        chart_runner = {1'b0, tbl_pid[k]};
        sched_now = sched_now + TIME_W'(1);
        mem_runner = {1'b0, tbl_pid[k]};
        // a zero burst still takes one unit of work
        if (tbl_remaining[k] <= BURST_W'(1)) begin
          ta = sched_now - {{(TIME_W-ARR_W){1'b0}}, tbl_arrival[k]};
          tbl_remaining[k] = '0;
          tbl_done[k] = 1'b1;
          retired_count++;
          mem_runner = IDLE_MARK;
          r.fin = 1'b1;
          r.tat = ta;
          r.wait_t = ta - {{(TIME_W-BURST_W){1'b0}}, tbl_burst[k]};
        end else begin
          tbl_remaining[k] = tbl_remaining[k] - BURST_W'(1);
        end
        scanning = 1'b0;
      end
    end
    r.drops = ndrop[DROP_W-1:0];
    r.all_fin = (retired_count >= tbl_count);
    return r;
  endfunction

  function automatic bit table_retired();
    return retired_count >= tbl_count;
  endfunction

  // update the predictor for one accepted command transfer
  function automatic void apply_command(logic [1:0] c, logic [PID_W-1:0] p,
                                        logic [ARR_W-1:0] a, logic [BURST_W-1:0] b,
                                        logic [PRIO_W-1:0] pr, logic f);
    case (c)
      OP_LOAD: begin
        // a load to a full table is dropped silently
        if (tbl_count < NPROC) begin
          tbl_pid[tbl_count] = p;
          tbl_arrival[tbl_count] = a;
          tbl_burst[tbl_count] = b;
          tbl_remaining[tbl_count] = b;
          tbl_prio[tbl_count] = pr;
          tbl_fits[tbl_count] = f;
          tbl_done[tbl_count] = 1'b0;
          tbl_count++;
          items_applied++;
        end
      end
      OP_TICK: begin
        tick_reports_due = {tick_reports_due, schedule_one_tick()};
        items_applied++;
      end
      OP_CLEAR: begin
        clear_table();
        items_applied++;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // mismatch reporting and result checking
  // ---------------------------------------------------------------------
  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want,
                             logic [TIME_W-1:0] at);
    if (got !== want) begin
      log_mismatch($sformatf("%s got %0h want %0h, tick at %0d", name, got, want, at));
    end
  endtask

  // results cannot be held off, so every strobe is taken on its edge
  always @(posedge clk) begin
    tick_report_t want;
    if (!rst && done) begin
      if (tick_reports_due.size() == 0) begin
        log_mismatch("tick report with no tick outstanding");
      end else begin
        want = tick_reports_due.pop_front();
        check_field("running_pid", 32'(running_pid), 32'(want.pid), want.tick_at);
        check_field("cpu_idle", 32'(cpu_idle), 32'(want.idle), want.tick_at);
        check_field("tick_time", 32'(tick_time), 32'(want.tick_at), want.tick_at);
        check_field("new_segment", 32'(new_segment), 32'(want.seg), want.tick_at);
        check_field("process_finished", 32'(process_finished), 32'(want.fin),
                    want.tick_at);
        check_field("turnaround", 32'(turnaround), 32'(want.tat), want.tick_at);
        check_field("waiting", 32'(waiting), 32'(want.wait_t), want.tick_at);
        check_field("dropped_count", 32'(dropped_count), 32'(want.drops), want.tick_at);
        check_field("all_done", 32'(all_done), 32'(want.all_fin), want.tick_at);
      end
    end
  end

  // ---------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------

  // one command transfer; start is left high on return so back-to-back
  // commands never lower and raise it within one step
  task automatic send_item(logic [1:0] c, logic [PID_W-1:0] p, logic [ARR_W-1:0] a,
                           logic [BURST_W-1:0] b, logic [PRIO_W-1:0] pr, logic f);
    int gap;
    gap = 0;
    if (!steady_mode && $urandom_range(99) < 17) begin
      // mostly short gaps, now and then long enough to span a whole tick
      gap = ($urandom_range(7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= c;
    process_pid <= p;
    arrival_time <= a;
    burst_length <= b;
    priority_level <= pr;
    fits_memory <= f;
    // accepted at the first edge that sees busy low
    do @(posedge clk); while (busy);
    apply_command(c, p, a, b, pr, f);
  endtask

  task automatic send_load(logic [PID_W-1:0] p, logic [ARR_W-1:0] a,
                           logic [BURST_W-1:0] b, logic [PRIO_W-1:0] pr, logic f);
    send_item(OP_LOAD, p, a, b, pr, f);
  endtask

  // tick and clear carry random payload the block must ignore
  task automatic send_tick();
    send_item(OP_TICK, PID_W'($urandom), ARR_W'($urandom), BURST_W'($urandom),
              PRIO_W'($urandom), 1'($urandom));
  endtask

  task automatic send_clear();
    send_item(OP_CLEAR, PID_W'($urandom), ARR_W'($urandom), BURST_W'($urandom),
              PRIO_W'($urandom), 1'($urandom));
  endtask

  // hold the sender off until every tick report has come back
  task automatic drain_reports();
    start <= 1'b0;
    do @(posedge clk); while (tick_reports_due.size() != 0);
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // empty table after reset: idle tick with all_done set, op 3 ignored
  task automatic test_empty_table();
    send_tick();
    send_item(OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    send_tick();
    drain_reports();
  endtask

  // field extremes and a zero burst; one entry never arrives
  task automatic test_field_extremes();
    send_clear();
    send_load(8'hFF, 16'h0000, 16'h0000, 8'hFF, 1'b1);
    send_load(8'h00, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0);
    send_load(8'hAA, 16'h0000, 16'h0001, 8'h00, 1'b1);
    repeat (3) send_tick();
    drain_reports();
  endtask

  // equal priorities go to the earliest entry, a later urgent one preempts
  task automatic test_tie_and_preempt();
    send_clear();
    send_load(8'd5, 16'd0, 16'd3, 8'd3, 1'b1);
    send_load(8'd6, 16'd0, 16'd1, 8'd3, 1'b1);
    send_load(8'd7, 16'd2, 16'd1, 8'd1, 1'b1);
    repeat (6) send_tick();
    drain_reports();
  endtask

  // memory failures: two drops in one tick, then a same-pid entry that
  // skips the memory check because its pid is already resident
  task automatic test_memory_drops();
    send_clear();
    send_load(8'd9, 16'd0, 16'd2, 8'd0, 1'b0);
    send_load(8'd10, 16'd0, 16'd2, 8'd1, 1'b0);
    send_load(8'd11, 16'd0, 16'd3, 8'd2, 1'b1);
    send_load(8'd11, 16'd1, 16'd1, 8'd1, 1'b0);
    repeat (5) send_tick();
    drain_reports();
  endtask

  task automatic random_load();
    logic [PID_W-1:0] p;
    logic [ARR_W-1:0] a;
    logic [BURST_W-1:0] b;
    logic [PRIO_W-1:0] pr;
    // a small pid pool makes repeated pids meet the resident-pid rule
    p = PID_W'(($urandom_range(1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 255));
    a = ARR_W'(($urandom_range(31) == 0) ? $urandom_range(0, 65535)
                                         : $urandom_range(0, 12));
    case ($urandom_range(31))
      0: b = BURST_W'($urandom_range(0, 65535));
      1: b = '0;
      default: b = BURST_W'($urandom_range(1, 6));
    endcase
    pr = PRIO_W'(($urandom_range(7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5));
    send_load(p, a, b, pr, $urandom_range(99) < 85);
  endtask

  // load a set of processes and tick until they are all retired or the tick cap is reached
  task automatic random_workload();
    int n;
    int ticks;
    if ($urandom_range(3) != 0) send_clear();
    // mostly small sets, sometimes past the table size
    n = ($urandom_range(7) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 8);
    repeat (n) random_load();
    ticks = 0;
    while (!table_retired() && ticks < 40) begin
      if ($urandom_range(19) == 0) random_load();
      send_tick();
      ticks++;
    end
    // a few idle ticks past the end of the chart
    repeat ($urandom_range(0, 2)) send_tick();
  endtask

  // any op with any payload, op 3 included
  task automatic random_noise();
    repeat ($urandom_range(1, 6)) begin
      send_item(2'($urandom_range(0, 3)), PID_W'($urandom), ARR_W'($urandom),
                BURST_W'($urandom), PRIO_W'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_random_traffic(int target);
    while (items_applied < target) begin
      // a long stretch with no random gaps between commands
      steady_mode = (items_applied >= 400 && items_applied < 600);
      if ($urandom_range(99) < 85) random_workload();
      else random_noise();
      if ($urandom_range(9) == 0) drain_reports();
    end
    steady_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------
  initial begin
    clear_table();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_field_extremes();
    test_tie_and_preempt();
    test_memory_drops();
    test_random_traffic(items_applied + 900);

    // wait out outstanding ticks, then watch for stray reports
    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tick_reports_due.size() != 0) begin
      log_mismatch($sformatf("%0d tick reports never arrived", tick_reports_due.size()));
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/pps_pkg.sv
rtl/pps_table.sv
rtl/preemptive_priority_scheduler.sv
rtl/pps_checker.sv
sim/preemptive_priority_scheduler_tb.sv
